/* hdl/assert_macros.svh */
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed: implication does not hold.");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed: next-cycle implication does not hold.");

`endif

/* hdl/rbmc_pkg.sv */
package rbmc_pkg;

   localparam logic [1:0] CSR_BLEND_MODE    = 2'd0;
   localparam logic [1:0] CSR_LAYER_OPACITY = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd3;

   localparam logic [2:0] MODE_NORMAL     = 3'd0;
   localparam logic [2:0] MODE_MULTIPLY   = 3'd1;
   localparam logic [2:0] MODE_SCREEN     = 3'd2;
   localparam logic [2:0] MODE_DARKEN     = 3'd3;
   localparam logic [2:0] MODE_LIGHTEN    = 3'd4;
   localparam logic [2:0] MODE_DIFFERENCE = 3'd5;
   localparam logic [2:0] MODE_EXCLUSION  = 3'd6;
   localparam logic [2:0] MODE_OVERLAY    = 3'd7;

   typedef struct packed {
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic [7:0]         src_red;
      logic [7:0]         src_green;
      logic [7:0]         src_blue;
      logic [7:0]         src_alpha;
      logic [7:0]         dst_red;
      logic [7:0]         dst_green;
      logic [7:0]         dst_blue;
      logic [7:0]         dst_alpha;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [27:0] pixel_index;
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [7:0]  out_alpha;
   } rsp_type;

   typedef struct packed {
      logic        we;
      logic [27:0] index;
      logic [7:0]  dst_red;
      logic [7:0]  dst_green;
      logic [7:0]  dst_blue;
      logic [7:0]  dst_alpha;
      logic [7:0]  oa;
   } side_type;

   // Truncating division by 255 for values below 2**24.
   function automatic logic [16:0] div255(input logic [23:0] x);
      logic [24:0] s;
      logic [16:0] q;
      logic [24:0] r;
      s = {1'b0, x} + {9'b0, x[23:8]};
      q = s[24:8];
      r = {1'b0, x} - ({q, 8'b0} - {8'b0, q});
      for (int i = 0; i < 3; i++) begin
         if (r >= 25'd255) begin
            q = q + 17'd1;
            r = r - 25'd255;
         end
      end
      return q;
   endfunction

endpackage

/* hdl/rbmc_div.sv */
module rbmc_div (
   input  logic        clock,
   input  logic        en,
   input  logic [16:0] num,
   input  logic [7:0]  den,
   output logic [7:0]  quo
);

   logic [16:0] rem_ff [4];
   logic [7:0]  den_ff [4];
   logic [7:0]  quo_ff [4];
   logic        sat_ff [4];

   logic [16:0] rem_src [4];
   logic [7:0]  den_src [4];
   logic [7:0]  quo_src [4];
   logic        sat_src [4];

   for (genvar k = 0; k < 4; k++) begin : g_stage
      logic [16:0] rem_in;
      logic [7:0]  quo_in;
      logic [16:0] sub_hi;
      logic [16:0] sub_lo;

      if (k == 0) begin : g_first
         assign rem_src[k] = num;
         assign den_src[k] = den;
         assign quo_src[k] = 8'd0;
         assign sat_src[k] = num >= {1'b0, den, 8'b0};
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign den_src[k] = den_ff[k-1];
         assign quo_src[k] = quo_ff[k-1];
         assign sat_src[k] = sat_ff[k-1];
      end

      assign sub_hi = {9'b0, den_src[k]} << (7 - 2 * k);
      assign sub_lo = {9'b0, den_src[k]} << (6 - 2 * k);

      always_comb begin
         rem_in = rem_src[k];
         quo_in = quo_src[k];
         if (rem_in >= sub_hi) begin
            rem_in = rem_in - sub_hi;
            quo_in[7 - 2 * k] = 1'b1;
         end
         if (rem_in >= sub_lo) begin
            rem_in = rem_in - sub_lo;
            quo_in[6 - 2 * k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src[k];
            quo_ff[k] <= quo_in;
            sat_ff[k] <= sat_src[k];
         end
      end
   end

   assign quo = sat_ff[3] ? 8'hFF : quo_ff[3];

endmodule

/* hdl/rgba_blend_mode_compositor_top.sv */
// Channel  | Direction | Ports
// request  | in        | req_valid, req_stall, req_data
// response | out       | rsp_valid, rsp_stall, rsp_data
// control  | in        | csr_write_enable, csr_index, csr_write_data
//
// One pixel is accepted every cycle while no result is held by rsp_stall.
// The item passes ten register stages: five for products and divides by 255, four for
// the colour divider and one result register.
// Reset clears the valid bits and sets the registers to mode normal, opacity 255, 1024 x 1024.
// While a result is held by rsp_stall the whole pipeline freezes and req_stall is raised.
module rgba_blend_mode_compositor_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rbmc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rbmc_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [14:0]          csr_write_data
);

   logic [2:0]  blend_mode_ff;
   logic [7:0]  layer_opacity_ff;
   logic [14:0] image_width_ff;
   logic [14:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff    <= rbmc_pkg::MODE_NORMAL;
         layer_opacity_ff <= 8'd255;
         image_width_ff   <= 15'd1024;
         image_height_ff  <= 15'd1024;
      end else if (csr_write_enable) begin
         case (csr_index)
            rbmc_pkg::CSR_BLEND_MODE:    blend_mode_ff    <= csr_write_data[2:0];
            rbmc_pkg::CSR_LAYER_OPACITY: layer_opacity_ff <= csr_write_data[7:0];
            rbmc_pkg::CSR_IMAGE_WIDTH:   image_width_ff   <= csr_write_data;
            rbmc_pkg::CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   logic [9:0] valid_ff;
   logic [9:0] valid_in;
   assign valid_in = {valid_ff[8:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end
   assign rsp_valid = valid_ff[9];

   // Stage 1: products.
   logic [7:0] s_in [3];
   logic [7:0] d_in [3];
   assign s_in[0] = req_data.src_red;
   assign s_in[1] = req_data.src_green;
   assign s_in[2] = req_data.src_blue;
   assign d_in[0] = req_data.dst_red;
   assign d_in[1] = req_data.dst_green;
   assign d_in[2] = req_data.dst_blue;

   logic        inside_in;
   logic [27:0] row_prod;
   assign inside_in = !req_data.x_coord[15] && !req_data.y_coord[15] &&
                      (req_data.x_coord[14:0] < image_width_ff) &&
                      (req_data.y_coord[14:0] < image_height_ff);
   assign row_prod  = 28'({15'b0, req_data.y_coord[14:0]} * {15'b0, image_width_ff});

   logic        s1_inside_ff;
   logic [27:0] s1_row_ff;
   logic [14:0] s1_x_ff;
   logic [15:0] s1_aprod_ff;
   logic [7:0]  s1_s_ff [3];
   logic [7:0]  s1_d_ff [3];
   logic [7:0]  s1_da_ff;
   logic [15:0] s1_psd_ff [3];
   logic [15:0] s1_pinv_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         s1_inside_ff <= inside_in;
         s1_row_ff    <= row_prod;
         s1_x_ff      <= req_data.x_coord[14:0];
         s1_aprod_ff  <= {8'b0, req_data.src_alpha} * {8'b0, layer_opacity_ff};
         s1_da_ff     <= req_data.dst_alpha;
         for (int c = 0; c < 3; c++) begin
            s1_s_ff[c]    <= s_in[c];
            s1_d_ff[c]    <= d_in[c];
            s1_psd_ff[c]  <= {8'b0, s_in[c]} * {8'b0, d_in[c]};
            s1_pinv_ff[c] <= {8'b0, 8'd255 - s_in[c]} * {8'b0, 8'd255 - d_in[c]};
         end
      end
   end

   // Stage 2: scaled alpha, blend mix and index.
   logic [7:0] a_in;
   logic       we_in;
   logic [7:0] mix_in [3];
   logic [16:0] a_q;
   assign a_q   = rbmc_pkg::div255({8'b0, s1_aprod_ff} + 24'd127);
   assign a_in  = a_q[7:0];
   assign we_in = s1_inside_ff && (a_in != 8'd0);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [16:0] mul_q;
         logic [16:0] scr_q;
         logic [16:0] mul2_q;
         logic [16:0] scr2_q;
         logic [8:0]  excl;
         mul_q  = rbmc_pkg::div255({8'b0, s1_psd_ff[c]});
         scr_q  = rbmc_pkg::div255({8'b0, s1_pinv_ff[c]});
         mul2_q = rbmc_pkg::div255({7'b0, s1_psd_ff[c], 1'b0});
         scr2_q = rbmc_pkg::div255({7'b0, s1_pinv_ff[c], 1'b0});
         excl   = {1'b0, s1_s_ff[c]} + {1'b0, s1_d_ff[c]} - mul2_q[8:0];
         case (blend_mode_ff)
            rbmc_pkg::MODE_MULTIPLY:   mix_in[c] = mul_q[7:0];
            rbmc_pkg::MODE_SCREEN:     mix_in[c] = 8'd255 - scr_q[7:0];
            rbmc_pkg::MODE_DARKEN:
               mix_in[c] = (s1_s_ff[c] < s1_d_ff[c]) ? s1_s_ff[c] : s1_d_ff[c];
            rbmc_pkg::MODE_LIGHTEN:
               mix_in[c] = (s1_s_ff[c] > s1_d_ff[c]) ? s1_s_ff[c] : s1_d_ff[c];
            rbmc_pkg::MODE_DIFFERENCE:
               mix_in[c] = (s1_s_ff[c] > s1_d_ff[c]) ? s1_s_ff[c] - s1_d_ff[c]
                                                     : s1_d_ff[c] - s1_s_ff[c];
            rbmc_pkg::MODE_EXCLUSION:  mix_in[c] = excl[7:0];
            rbmc_pkg::MODE_OVERLAY:
               mix_in[c] = s1_d_ff[c][7] ? 8'd255 - scr2_q[7:0] : mul2_q[7:0];
            default:                   mix_in[c] = s1_s_ff[c];
         endcase
      end
   end

   logic [7:0]  s2_a_ff;
   logic        s2_we_ff;
   logic [27:0] s2_index_ff;
   logic [7:0]  s2_m_ff [3];
   logic [7:0]  s2_d_ff [3];
   logic [7:0]  s2_da_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_a_ff     <= a_in;
         s2_we_ff    <= we_in;
         s2_index_ff <= we_in ? s1_row_ff + {13'b0, s1_x_ff} : 28'd0;
         s2_da_ff    <= s1_da_ff;
         for (int c = 0; c < 3; c++) begin
            s2_m_ff[c] <= mix_in[c];
            s2_d_ff[c] <= s1_d_ff[c];
         end
      end
   end

   // Stage 3: alpha products.
   logic [7:0] ia_in;
   assign ia_in = 8'd255 - s2_a_ff;

   logic [7:0]  s3_a_ff;
   logic [7:0]  s3_ia_ff;
   logic        s3_we_ff;
   logic [27:0] s3_index_ff;
   logic [15:0] s3_pdi_ff;
   logic [15:0] s3_psa_ff [3];
   logic [15:0] s3_pdd_ff [3];
   logic [7:0]  s3_d_ff [3];
   logic [7:0]  s3_da_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_a_ff     <= s2_a_ff;
         s3_ia_ff    <= ia_in;
         s3_we_ff    <= s2_we_ff;
         s3_index_ff <= s2_index_ff;
         s3_pdi_ff   <= {8'b0, s2_da_ff} * {8'b0, ia_in};
         s3_da_ff    <= s2_da_ff;
         for (int c = 0; c < 3; c++) begin
            s3_psa_ff[c] <= {8'b0, s2_m_ff[c]} * {8'b0, s2_a_ff};
            s3_pdd_ff[c] <= {8'b0, s2_d_ff[c]} * {8'b0, s2_da_ff};
            s3_d_ff[c]   <= s2_d_ff[c];
         end
      end
   end

   // Stage 4: output alpha and destination weight.
   logic [16:0] oa_q;
   assign oa_q = rbmc_pkg::div255({8'b0, s3_pdi_ff} + 24'd127);

   logic [7:0]  s4_oa_ff;
   logic        s4_we_ff;
   logic [27:0] s4_index_ff;
   logic [23:0] s4_t_ff [3];
   logic [15:0] s4_psa_ff [3];
   logic [7:0]  s4_d_ff [3];
   logic [7:0]  s4_da_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_oa_ff    <= s3_a_ff + oa_q[7:0];
         s4_we_ff    <= s3_we_ff;
         s4_index_ff <= s3_index_ff;
         s4_da_ff    <= s3_da_ff;
         for (int c = 0; c < 3; c++) begin
            s4_t_ff[c]   <= {8'b0, s3_pdd_ff[c]} * {16'b0, s3_ia_ff};
            s4_psa_ff[c] <= s3_psa_ff[c];
            s4_d_ff[c]   <= s3_d_ff[c];
         end
      end
   end

   // Stage 5: numerators.
   logic [16:0] t_q [3];
   for (genvar c = 0; c < 3; c++) begin : g_tq
      assign t_q[c] = rbmc_pkg::div255(s4_t_ff[c]);
   end

   logic [16:0] s5_num_ff [3];
   rbmc_pkg::side_type s5_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            s5_num_ff[c] <= {1'b0, s4_psa_ff[c]} + t_q[c] + {10'b0, s4_oa_ff[7:1]};
         end
         s5_side_ff.we        <= s4_we_ff;
         s5_side_ff.index     <= s4_index_ff;
         s5_side_ff.dst_red   <= s4_d_ff[0];
         s5_side_ff.dst_green <= s4_d_ff[1];
         s5_side_ff.dst_blue  <= s4_d_ff[2];
         s5_side_ff.dst_alpha <= s4_da_ff;
         s5_side_ff.oa        <= s4_oa_ff;
      end
   end

   // Stages 6 to 9: colour division by the output alpha.
   logic [7:0] quo [3];
   for (genvar c = 0; c < 3; c++) begin : g_div
      rbmc_div u_div (
         .clock (clock),
         .en    (en),
         .num   (s5_num_ff[c]),
         .den   (s5_side_ff.oa),
         .quo   (quo[c])
      );
   end

   rbmc_pkg::side_type side_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s5_side_ff;
         for (int k = 1; k < 4; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Stage 10: result register.
   rbmc_pkg::rsp_type rsp_ff;
   rbmc_pkg::rsp_type rsp_in;
   always_comb begin
      rsp_in.write_enable = side_ff[3].we;
      rsp_in.pixel_index  = side_ff[3].index;
      rsp_in.out_red      = side_ff[3].we ? quo[0] : side_ff[3].dst_red;
      rsp_in.out_green    = side_ff[3].we ? quo[1] : side_ff[3].dst_green;
      rsp_in.out_blue     = side_ff[3].we ? quo[2] : side_ff[3].dst_blue;
      rsp_in.out_alpha    = side_ff[3].we ? side_ff[3].oa : side_ff[3].dst_alpha;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp_data = rsp_ff;

endmodule

/* hdl/rbmc_checker.sv */
`include "assert_macros.svh"

module rbmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rbmc_pkg::rsp_type rsp_data
);

   `ASSERT_IMPLIES(a_no_write_zero_index, clock, reset,
      rsp_valid && !rsp_data.write_enable, rsp_data.pixel_index == 28'd0)
   `ASSERT_IMPLIES(a_stall_backs_up, clock, reset, rsp_valid && rsp_stall, req_stall)
   `ASSERT_NEXT(a_held_result, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind rgba_blend_mode_compositor_top rbmc_checker u_rbmc_checker (.*);

/* tb/tb_rgba_blend_mode_compositor_top.sv */
`timescale 1ns / 1ps

module tb_rgba_blend_mode_compositor_top;

   localparam int LATENCY = 10;
   localparam int IDLE_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rbmc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rbmc_pkg::rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [14:0] csr_write_data = '0;

   rgba_blend_mode_compositor_top dut (.*);

   always #5 clock = ~clock;

   logic [2:0] mode_reg;
   logic [7:0] opacity_reg;
   logic [14:0] width_reg;
   logic [14:0] height_reg;

   rbmc_pkg::req_type pending_pixels[$];
   rbmc_pkg::rsp_type expected_pixels[$];
   int mismatches = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   int writes_seen = 0;
   int idle_cycles = 0;
   int hold_cycles = 0;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;
   bit quiet_phase = 1'b0;
   bit timed_out = 1'b0;

   function automatic int unsigned mix_channel(int unsigned s, int unsigned d);
      case (mode_reg)
         rbmc_pkg::MODE_MULTIPLY: return s * d / 255;
         rbmc_pkg::MODE_SCREEN: return 255 - (255 - s) * (255 - d) / 255;
         rbmc_pkg::MODE_DARKEN: return s < d ? s : d;
         rbmc_pkg::MODE_LIGHTEN: return s > d ? s : d;
         rbmc_pkg::MODE_DIFFERENCE: return s > d ? s - d : d - s;
         rbmc_pkg::MODE_EXCLUSION: return (s + d - 2 * s * d / 255) & 8'hff;
         rbmc_pkg::MODE_OVERLAY: begin
            if (d < 128) return 2 * s * d / 255;
            return 255 - 2 * (255 - s) * (255 - d) / 255;
         end
         default: return s;
      endcase
   endfunction

   function automatic logic [7:0] over_channel(int unsigned s, int unsigned d,
         int unsigned a, int unsigned da, int unsigned oa);
      int unsigned v;
      v = (s * a + d * da * (255 - a) / 255 + oa / 2) / oa;
      return v > 255 ? 8'd255 : v[7:0];
   endfunction

   function automatic rbmc_pkg::rsp_type composite_pixel(rbmc_pkg::req_type p);
      rbmc_pkg::rsp_type r;
      int unsigned a, oa, sr, sg, sb, xu, yu, da;
      bit in_image;
      xu = 32'(p.x_coord[14:0]);
      yu = 32'(p.y_coord[14:0]);
      da = 32'(p.dst_alpha);
      in_image = !p.x_coord[15] && !p.y_coord[15] &&
                 xu < 32'(width_reg) && yu < 32'(height_reg);
      a = (32'(p.src_alpha) * 32'(opacity_reg) + 127) / 255;
      r = '0;
      r.out_red = p.dst_red;
      r.out_green = p.dst_green;
      r.out_blue = p.dst_blue;
      r.out_alpha = p.dst_alpha;
      if (!in_image || a == 0) return r;
      sr = mix_channel(32'(p.src_red), 32'(p.dst_red));
      sg = mix_channel(32'(p.src_green), 32'(p.dst_green));
      sb = mix_channel(32'(p.src_blue), 32'(p.dst_blue));
      r.write_enable = 1'b1;
      r.pixel_index = 28'(yu * 32'(width_reg) + xu);
      if (a == 255) begin
         r.out_red = sr[7:0];
         r.out_green = sg[7:0];
         r.out_blue = sb[7:0];
         r.out_alpha = 8'd255;
      end else begin
         oa = a + (da * (255 - a) + 127) / 255;
         r.out_red = over_channel(sr, 32'(p.dst_red), a, da, oa);
         r.out_green = over_channel(sg, 32'(p.dst_green), a, da, oa);
         r.out_blue = over_channel(sb, 32'(p.dst_blue), a, da, oa);
         r.out_alpha = oa[7:0];
      end
      return r;
   endfunction

   // The driver offers pending pixels; the prediction is taken at each transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_pixels = {expected_pixels, composite_pixel(req_data)};
            pixels_sent++;
         end
         if ((!req_valid || !req_stall) && pending_pixels.size() > 0 &&
               (quiet_phase || $urandom_range(99) >= 20)) begin
            req_data <= pending_pixels.pop_front();
            req_valid <= 1'b1;
         end else if (!req_valid || !req_stall) begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            pixels_checked++;
            if (rsp_data.write_enable) writes_seen++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_data);
            end else begin
               rbmc_pkg::rsp_type e;
               e = expected_pixels.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected we %b idx %0d rgba %h %h %h %h,",
                               " got we %b idx %0d rgba %h %h %h %h"},
                        e.write_enable, e.pixel_index, e.out_red, e.out_green,
                        e.out_blue, e.out_alpha, rsp_data.write_enable,
                        rsp_data.pixel_index, rsp_data.out_red, rsp_data.out_green,
                        rsp_data.out_blue, rsp_data.out_alpha);
               end
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cycles = 60;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_phase && $urandom_range(99) < 20;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset ||
            (pending_pixels.size() == 0 && expected_pixels.size() == 0 && !req_valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         timed_out = 1'b1;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (timed_out);
      $display("tb: failure");
      $finish;
   end

   task automatic queue_pixel(rbmc_pkg::req_type p);
      pending_pixels = {pending_pixels, p};
   endtask

   task automatic write_register(logic [1:0] idx, logic [14:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rbmc_pkg::CSR_BLEND_MODE: mode_reg = value[2:0];
         rbmc_pkg::CSR_LAYER_OPACITY: opacity_reg = value[7:0];
         rbmc_pkg::CSR_IMAGE_WIDTH: width_reg = value;
         rbmc_pkg::CSR_IMAGE_HEIGHT: height_reg = value;
         default: ;
      endcase
   endtask

   task automatic drain_pipeline();
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   function automatic rbmc_pkg::req_type random_pixel(bit in_image);
      rbmc_pkg::req_type p;
      p = rbmc_pkg::req_type'({$urandom, $urandom, $urandom});
      if (in_image && $urandom_range(9) < 8) begin
         p.x_coord = 16'($urandom_range(width_reg > 0 ? width_reg - 1 : 0));
         p.y_coord = 16'($urandom_range(height_reg > 0 ? height_reg - 1 : 0));
      end
      case ($urandom_range(5))
         0: p.src_alpha = 8'd255;
         1: p.src_alpha = 8'd0;
         default: ;
      endcase
      return p;
   endfunction

   function automatic rbmc_pkg::req_type fixed_pixel(int x, int y, logic [31:0] src,
         logic [31:0] dst);
      rbmc_pkg::req_type p;
      p.x_coord = 16'(x);
      p.y_coord = 16'(y);
      {p.src_red, p.src_green, p.src_blue, p.src_alpha} = src;
      {p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha} = dst;
      return p;
   endfunction

   initial begin
      logic [2:0] modes[8];
      logic [14:0] sizes[6];
      mode_reg = rbmc_pkg::MODE_NORMAL;
      opacity_reg = 8'd255;
      width_reg = 15'd1024;
      height_reg = 15'd1024;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed corners at the reset settings.
      queue_pixel(fixed_pixel(0, 0, 32'hffffffff, 32'h00000000));
      queue_pixel(fixed_pixel(1023, 1023, 32'h123456ff, 32'h0));
      queue_pixel(fixed_pixel(1024, 5, 32'hffffff80, 32'h11223344));
      queue_pixel(fixed_pixel(5, 1024, 32'hffffff80, 32'h11223344));
      queue_pixel(fixed_pixel(-1, 3, 32'hffffff80, 32'h11223344));
      queue_pixel(fixed_pixel(3, -32768, 32'hffffff80, 32'h11223344));
      queue_pixel(fixed_pixel(32767, 32767, 32'hffffff80, 32'h11223344));
      queue_pixel(fixed_pixel(7, 9, 32'hff000000, 32'haabbccdd));
      queue_pixel(fixed_pixel(7, 9, 32'hffffff01, 32'hffffffff));
      queue_pixel(fixed_pixel(8, 9, 32'hffffff01, 32'h00000000));
      queue_pixel(fixed_pixel(8, 9, 32'hff00fffe, 32'hffffff00));
      drain_pipeline();

      modes = '{rbmc_pkg::MODE_MULTIPLY, rbmc_pkg::MODE_SCREEN, rbmc_pkg::MODE_DARKEN,
                rbmc_pkg::MODE_LIGHTEN, rbmc_pkg::MODE_DIFFERENCE,
                rbmc_pkg::MODE_EXCLUSION, rbmc_pkg::MODE_OVERLAY, rbmc_pkg::MODE_NORMAL};
      sizes = '{15'd16384, 15'd1, 15'd0, 15'd37, 15'd32767, 15'd300};
      foreach (modes[m]) begin
         write_register(rbmc_pkg::CSR_BLEND_MODE, {12'b0, modes[m]});
         write_register(rbmc_pkg::CSR_LAYER_OPACITY,
            15'(m == 0 ? 0 : (m == 1 ? 255 : $urandom_range(255))));
         write_register(rbmc_pkg::CSR_IMAGE_WIDTH, sizes[m % 6]);
         write_register(rbmc_pkg::CSR_IMAGE_HEIGHT, sizes[(m + 3) % 6]);
         if (m < 2) begin
            queue_pixel(fixed_pixel(0, 0, 32'hff80017f, 32'h7f80ffc0));
            queue_pixel(fixed_pixel(0, 0, 32'h00ff80c0, 32'hff0080ff));
         end
         quiet_phase = (m == 3);
         if (m == 4) hold_request = 1'b1;
         for (int i = 0; i < 118; i++)
            queue_pixel(random_pixel($urandom_range(3) != 0));
         drain_pipeline();
         quiet_phase = 1'b0;
      end

      $display("covered %0d pixels across all eight blend modes, opacity and size extremes",
         pixels_sent);
      $display("%0d results checked, %0d of them pixel writes", pixels_checked, writes_seen);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
